@@ rtl/arm_pkg.sv @@
// ---------------------------------------------------------------------------
// arm_pkg: shared types and codes of the anomaly rule matcher
// Request and condition codes, the stored rule record and the control
// group that the sequencer sends to the rule table.
// ---------------------------------------------------------------------------
package arm_pkg;

   // Request codes carried in req_type.
   localparam logic [1:0] REQ_RECORD     = 2'd0;
   localparam logic [1:0] REQ_WRITE      = 2'd1;
   localparam logic [1:0] REQ_ACTIVATE   = 2'd2;
   localparam logic [1:0] REQ_DEACTIVATE = 2'd3;

   // Rule conditions as stored in the table.
   localparam logic [1:0] COND_SINGLE     = 2'd0;
   localparam logic [1:0] COND_CONTINUOUS = 2'd1;
   localparam logic [1:0] COND_CUMULATIVE = 2'd2;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_ILLEGAL = 1'b1;

   // Fields of one rule that only a rule write changes.
   typedef struct packed {
      logic [7:0] grp;
      logic [7:0] lcl;
      logic [1:0] cond;
      logic [7:0] thr;
      logic [7:0] action;
   } rule_param_type;

   // Write strobes from the sequencer to the rule table.
   typedef struct packed {
      logic param_we;
      logic cd_we;
      logic act_set;
      logic act_clr;
   } tbl_ctl_type;

endpackage

@@ rtl/arm_req_if.sv @@
// ---------------------------------------------------------------------------
// arm_req_if: request channel of the anomaly rule matcher
// Valid/ready channel that carries one request item per handshake.
// ---------------------------------------------------------------------------
interface arm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  rule_index;
   logic [7:0]  code_group;
   logic [7:0]  code_local;
   logic [7:0]  condition;
   logic [7:0]  threshold;
   logic [7:0]  action_id;
   logic [15:0] repeat_count;
   logic        newest_flag;

   modport source (
      output valid, req_type, rule_index, code_group, code_local, condition,
             threshold, action_id, repeat_count, newest_flag,
      input  ready
   );

   modport sink (
      input  valid, req_type, rule_index, code_group, code_local, condition,
             threshold, action_id, repeat_count, newest_flag,
      output ready
   );
endinterface

@@ rtl/arm_rsp_if.sv @@
// ---------------------------------------------------------------------------
// arm_rsp_if: response channel of the anomaly rule matcher
// Valid/ready channel that carries one response item per handshake.
// ---------------------------------------------------------------------------
interface arm_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic        fired;
   logic [4:0]  fired_rule;
   logic [7:0]  fired_action;
   logic [15:0] responses_total;

   modport source (
      output valid, status, fired, fired_rule, fired_action, responses_total,
      input  ready
   );

   modport sink (
      input  valid, status, fired, fired_rule, fired_action, responses_total,
      output ready
   );
endinterface

@@ rtl/anomaly_rule_matcher.sv @@
// ---------------------------------------------------------------------------
// anomaly_rule_matcher: response rule table matched against anomaly records
// Keeps RULE_SLOTS rules and answers each request item with one response.
// ---------------------------------------------------------------------------
// Requests arrive on req_chan (valid/ready) and every request gives exactly
// one response on rsp_chan (valid/ready). Write, activate and deactivate
// requests manage the rule table; an anomaly record is matched against the
// rules in index order and the first hit deactivates its rule, bumps the
// response count and returns its action id.
// Write and deactivate requests go straight to the result step; activate
// does one table read before the countdown reload; a record is scanned
// by the sequencer, which checks one rule per cycle and stops at a hit.
// req_chan.ready is high only while no request is in work, so a new
// request is taken only after the last one has passed the result step.
// The response sits in an output register; while the receiver stalls, the
// next request is taken and worked, but it waits before the result step
// until the register is free.
// Reset clears all active flags, the response count and the channel state;
// rule contents stay undefined until written.
// ---------------------------------------------------------------------------
module anomaly_rule_matcher import arm_pkg::*; #(
   parameter int RULE_SLOTS = 16,
   localparam int IdxW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1
) (
   input  logic      clock,
   input  logic      reset,
   arm_req_if.sink   req_chan,
   arm_rsp_if.source rsp_chan
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_ACT  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   localparam logic [IdxW-1:0] LAST_IDX  = IdxW'(RULE_SLOTS - 1);
   localparam logic [4:0]      RULE_NONE = 5'(RULE_SLOTS % 32);

   state_type       state_ff, state_in;
   logic [IdxW-1:0] scan_idx_ff, scan_idx_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [7:0]      grp_ff, grp_in;
   logic [7:0]      lcl_ff, lcl_in;
   logic [15:0]     run_ff, run_in;
   logic            latest_ff, latest_in;
   logic [15:0]     count_ff, count_in;
   logic            res_status_ff, res_status_in;
   logic            res_fired_ff, res_fired_in;
   logic [4:0]      res_rule_ff, res_rule_in;
   logic [7:0]      res_action_ff, res_action_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_status_ff, rsp_status_in;
   logic            rsp_fired_ff, rsp_fired_in;
   logic [4:0]      rsp_rule_ff, rsp_rule_in;
   logic [7:0]      rsp_action_ff, rsp_action_in;
   logic [15:0]     rsp_total_ff, rsp_total_in;

   tbl_ctl_type     tbl_ctl;
   logic [IdxW-1:0] wr_addr;
   logic [IdxW-1:0] rd_addr;
   rule_param_type  param_wdata;
   logic [7:0]      cd_wdata;
   rule_param_type  rd_param;
   logic [7:0]      rd_cd;
   logic            rd_active;

   logic            req_fire;
   logic            idx_ok;
   logic            codes_eq;
   logic            cond_hit;
   logic            scan_hit;
   logic            out_free;

   arm_rule_table #(.RULE_SLOTS(RULE_SLOTS)) u_table (
      .clock       (clock),
      .reset       (reset),
      .ctl         (tbl_ctl),
      .wr_addr     (wr_addr),
      .param_wdata (param_wdata),
      .cd_wdata    (cd_wdata),
      .rd_addr     (rd_addr),
      .rd_param    (rd_param),
      .rd_cd       (rd_cd),
      .rd_active   (rd_active)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign idx_ok         = 9'(req_chan.rule_index) < 9'(RULE_SLOTS);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Rule check for the entry whose read data is present in this cycle.
   assign codes_eq = rd_active && (rd_param.grp == grp_ff) && (rd_param.lcl == lcl_ff);

   always_comb begin
      case (rd_param.cond)
         COND_SINGLE:     cond_hit = 1'b1;
         COND_CONTINUOUS: cond_hit = {8'b0, rd_param.thr} < run_ff;
         COND_CUMULATIVE: cond_hit = {8'b0, rd_cd} <= run_ff;
         default:         cond_hit = 1'b0;
      endcase
   end

   assign scan_hit = (state_ff == ST_SCAN) && codes_eq && cond_hit;

   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      idx_in        = idx_ff;
      grp_in        = grp_ff;
      lcl_in        = lcl_ff;
      run_in        = run_ff;
      latest_in     = latest_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_fired_in  = res_fired_ff;
      res_rule_in   = res_rule_ff;
      res_action_in = res_action_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_rule_in   = rsp_rule_ff;
      rsp_action_in = rsp_action_ff;
      rsp_total_in  = rsp_total_ff;

      tbl_ctl            = '0;
      wr_addr            = req_chan.rule_index[IdxW-1:0];
      rd_addr            = req_chan.rule_index[IdxW-1:0];
      param_wdata.grp    = req_chan.code_group;
      param_wdata.lcl    = req_chan.code_local;
      param_wdata.cond   = req_chan.condition[1:0];
      param_wdata.thr    = req_chan.threshold;
      param_wdata.action = req_chan.action_id;
      cd_wdata           = req_chan.threshold;

      case (state_ff)
         ST_IDLE: begin
            scan_idx_in = '0;
            if (req_chan.req_type == REQ_RECORD) begin
               rd_addr = '0;
            end
            if (req_fire) begin
               idx_in        = req_chan.rule_index[IdxW-1:0];
               grp_in        = req_chan.code_group;
               lcl_in        = req_chan.code_local;
               run_in        = req_chan.repeat_count;
               latest_in     = req_chan.newest_flag;
               res_status_in = STATUS_OK;
               res_fired_in  = 1'b0;
               res_rule_in   = RULE_NONE;
               res_action_in = '0;
               state_in      = ST_FIN;
               if (req_chan.req_type == REQ_RECORD) begin
                  state_in = ST_SCAN;
               end else if (!idx_ok) begin
                  res_status_in = STATUS_ILLEGAL;
               end else begin
                  case (req_chan.req_type)
                     REQ_WRITE: begin
                        if (req_chan.condition > {6'b0, COND_CUMULATIVE}) begin
                           res_status_in = STATUS_ILLEGAL;
                        end else begin
                           tbl_ctl.param_we = 1'b1;
                           tbl_ctl.cd_we    = 1'b1;
                           tbl_ctl.act_clr  = 1'b1;
                        end
                     end
                     REQ_ACTIVATE: begin
                        state_in = ST_ACT;
                     end
                     default: begin
                        tbl_ctl.act_clr = 1'b1;
                     end
                  endcase
               end
            end
         end
         ST_SCAN: begin
            rd_addr     = scan_idx_ff + IdxW'(1);
            wr_addr     = scan_idx_ff;
            cd_wdata    = rd_cd - run_ff[7:0];
            scan_idx_in = scan_idx_ff + IdxW'(1);
            if (scan_hit) begin
               tbl_ctl.act_clr = 1'b1;
               res_fired_in    = 1'b1;
               res_rule_in     = 5'(scan_idx_ff);
               res_action_in   = rd_param.action;
               count_in        = count_ff + 16'd1;
               state_in        = ST_FIN;
            end else begin
               // A cumulative miss on a non-newest record keeps what it counted.
               if (codes_eq && (rd_param.cond == COND_CUMULATIVE) && !latest_ff) begin
                  tbl_ctl.cd_we = 1'b1;
               end
               if (scan_idx_ff == LAST_IDX) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_ACT: begin
            wr_addr         = idx_ff;
            rd_addr         = idx_ff;
            cd_wdata        = rd_param.thr;
            tbl_ctl.cd_we   = 1'b1;
            tbl_ctl.act_set = 1'b1;
            state_in        = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_fired_in  = res_fired_ff;
               rsp_rule_in   = res_rule_ff;
               rsp_action_in = res_action_ff;
               rsp_total_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_idx_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      grp_ff        <= grp_in;
      lcl_ff        <= lcl_in;
      run_ff        <= run_in;
      latest_ff     <= latest_in;
      res_status_ff <= res_status_in;
      res_fired_ff  <= res_fired_in;
      res_rule_ff   <= res_rule_in;
      res_action_ff <= res_action_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_rule_ff   <= rsp_rule_in;
      rsp_action_ff <= rsp_action_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.fired           = rsp_fired_ff;
   assign rsp_chan.fired_rule      = rsp_rule_ff;
   assign rsp_chan.fired_action    = rsp_action_ff;
   assign rsp_chan.responses_total = rsp_total_ff;

`ifndef SYNTHESIS
   // The response count moves only on a rule hit found by the scan.
   a_count_on_hit: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(scan_hit))
      else $error("response count changed without a rule hit");

   // A hit ends the scan at once.
   a_hit_ends_scan: assert property (@(posedge clock) disable iff (reset)
      scan_hit |=> (state_ff == ST_FIN))
      else $error("scan went on after a rule hit");

   // A response never reports an illegal request and a fired rule together.
   a_status_fired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_status_ff && rsp_fired_ff))
      else $error("response is both illegal and fired");

   // A new response is loaded only when the output register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready && (state_ff == ST_FIN)) |=>
         (state_ff == ST_FIN))
      else $error("result step left while the output register was full");
`endif

endmodule

@@ rtl/arm_rule_table.sv @@
// ---------------------------------------------------------------------------
// arm_rule_table: storage of the response rules
// Parameter and countdown memories with one write and one registered read
// port each, plus the active flags held in flip-flops.
// ---------------------------------------------------------------------------
module arm_rule_table import arm_pkg::*; #(
   parameter int RULE_SLOTS = 16,
   localparam int IdxW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  tbl_ctl_type    ctl,
   input  logic [IdxW-1:0] wr_addr,
   input  rule_param_type param_wdata,
   input  logic [7:0]     cd_wdata,
   input  logic [IdxW-1:0] rd_addr,
   output rule_param_type rd_param,
   output logic [7:0]     rd_cd,
   output logic           rd_active
);

   rule_param_type             param_mem_ff [RULE_SLOTS];
   logic [7:0]                 cd_mem_ff    [RULE_SLOTS];
   logic [RULE_SLOTS-1:0]      active_ff;
   rule_param_type             rd_param_ff;
   logic [7:0]                 rd_cd_ff;
   logic                       rd_active_ff;

   always_ff @(posedge clock) begin
      if (ctl.param_we) begin
         param_mem_ff[wr_addr] <= param_wdata;
      end
      if (ctl.cd_we) begin
         cd_mem_ff[wr_addr] <= cd_wdata;
      end
      rd_param_ff <= param_mem_ff[rd_addr];
      rd_cd_ff    <= cd_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         rd_active_ff <= 1'b0;
      end else begin
         if (ctl.act_set) begin
            active_ff[wr_addr] <= 1'b1;
         end else if (ctl.act_clr) begin
            active_ff[wr_addr] <= 1'b0;
         end
         rd_active_ff <= active_ff[rd_addr];
      end
   end

   assign rd_param  = rd_param_ff;
   assign rd_cd     = rd_cd_ff;
   assign rd_active = rd_active_ff;

endmodule
